FILE: sv/rqfi_pkg.sv
// Shared types and constants for the ring queue with front insert.
// No dependencies; used by rqfi_ctrl, rqfi_dpath and the top level.
package rqfi_pkg;

   localparam int RING_SLOTS_DEF = 64;
   localparam int ENTRY_BITS_DEF = 32;
   localparam int CAP_W          = 6;
   localparam int OCC_W          = 6;
   localparam int CAP_RESET      = 63;

   typedef enum logic [2:0] {
      KIND_PUSH_TAIL  = 3'd0,
      KIND_POP        = 3'd1,
      KIND_PEEK       = 3'd2,
      KIND_PUSH_FRONT = 3'd3,
      KIND_DRAIN      = 3'd4,
      KIND_COUNT      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NULL  = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // take the request beat and do its operation
      logic emit;        // load the result register from the read data
      logic drain_next;  // issue the next drain read
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_read;  // pending request needs a memory read
      logic drain_more;  // drain has entries left after the current one
      logic out_free;    // result register can take a beat this cycle
   } stat_type;

endpackage

FILE: sv/ring_queue_with_front_insert_core.sv
// Ring queue with front insert: top level joining sequencer and datapath.
// Non-empty pop, peek and drain, and evicting push front, go through the registered memory
// read; other answered beats fill the result register on accept. Non-reading kinds take
// 1 beat/cycle while results are taken; a reading kind holds off requests until its result
// is loaded. Drain streams 1 entry/cycle, likewise, paced by the single read port.
// Sync reset: empty ring, capacity 63, no sweep. Uses rqfi_pkg, rqfi_ctrl, rqfi_dpath.
module ring_queue_with_front_insert_core #(
   parameter int RING_SLOTS = rqfi_pkg::RING_SLOTS_DEF,
   parameter int ENTRY_BITS = rqfi_pkg::ENTRY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_kind,
   input  logic [ENTRY_BITS-1:0]       req_entry_in,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [ENTRY_BITS-1:0]       rsp_entry_out,
   output logic                        rsp_evicted,
   output logic [ENTRY_BITS-1:0]       rsp_evicted_entry,
   output logic [rqfi_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                        rsp_last,
   // capacity register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rqfi_pkg::CAP_W-1:0]  csr_data
);

   // cmd: what the sequencer wants done this cycle
   // stat: what the datapath knows about the pending beat and the result register
   rqfi_pkg::cmd_type  cmd;
   rqfi_pkg::stat_type stat;

   // The user must send capacity writes only while the block is quiet; the block does not
   // enforce it; the port never stalls. A write rewinds head and tail to the new ring top.
   assign csr_ready = 1'b1;

   // Sequencer: in idle it takes a request beat whenever the result register is free
   // or being taken this cycle; beats that need a slot memory read go through the read
   // state, where drain keeps issuing one read per delivered entry.
   rqfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot memory, pointers modulo capacity+1 (clamped to RING_SLOTS),
   // and the result register that parts the two channels.
   rqfi_dpath #(
      .RING_SLOTS (RING_SLOTS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_entry_in      (req_entry_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_entry_out     (rsp_entry_out),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_entry (rsp_evicted_entry),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data)
   );

endmodule

FILE: sv/rqfi_ctrl.sv
// Sequencer for the ring queue: idle/accept and read-result states.
// Depends on rqfi_pkg (cmd_type, stat_type).
module rqfi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rqfi_pkg::stat_type  stat,
   output rqfi_pkg::cmd_type   cmd
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.needs_read) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.drain_more) begin
                  cmd.drain_next = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/rqfi_dpath.sv
// Datapath of the ring queue: slot memory, head/tail pointers, ring top, result register.
// Depends on rqfi_pkg; driven by rqfi_ctrl through cmd_type / stat_type.
module rqfi_dpath #(
   parameter int RING_SLOTS = rqfi_pkg::RING_SLOTS_DEF,
   parameter int ENTRY_BITS = rqfi_pkg::ENTRY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rqfi_pkg::cmd_type               cmd,
   output rqfi_pkg::stat_type              stat,
   input  logic [2:0]                      req_kind,
   input  logic [ENTRY_BITS-1:0]           req_entry_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [ENTRY_BITS-1:0]           rsp_entry_out,
   output logic                            rsp_evicted,
   output logic [ENTRY_BITS-1:0]           rsp_evicted_entry,
   output logic [rqfi_pkg::OCC_W-1:0]      rsp_occupancy,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   input  logic [rqfi_pkg::CAP_W-1:0]      csr_data
);

   localparam int IDX_W   = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int HW      = (IDX_W + 1 > rqfi_pkg::OCC_W) ? IDX_W + 1 : rqfi_pkg::OCC_W;
   localparam int CW      = (IDX_W + 1 > rqfi_pkg::CAP_W + 1) ? IDX_W + 1
                                                               : rqfi_pkg::CAP_W + 1;
   localparam int CAP_EFF = (rqfi_pkg::CAP_RESET == 0) ? 1 : rqfi_pkg::CAP_RESET;
   localparam int TOP_RST = ((CAP_EFF + 1 > RING_SLOTS) ? RING_SLOTS : CAP_EFF + 1) - 1;
   localparam int OW      = rqfi_pkg::OCC_W;

   logic [ENTRY_BITS-1:0] slot_store_ff [RING_SLOTS];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in, top_ff, top_in;
   logic [IDX_W-1:0] remain_ff, remain_in;
   logic             pend_evict_ff, pend_evict_in, pend_drain_ff, pend_drain_in;
   logic [OW-1:0]    pend_occ_ff, pend_occ_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rqfi_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [ENTRY_BITS-1:0] rsp_entry_out_ff, rsp_entry_out_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [ENTRY_BITS-1:0] rsp_evicted_entry_ff, rsp_evicted_entry_in;
   logic [OW-1:0]         rsp_occupancy_ff, rsp_occupancy_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  we, re;
   logic [IDX_W-1:0]      waddr, raddr;
   logic [IDX_W-1:0]      up_head, up_tail, dn_head, dn_tail, top_new;
   logic                  is_empty, is_full, is_null;
   logic [HW-1:0]         held;
   logic [OW-1:0]         occ;
   logic [CW-1:0]         cap_eff, mod_new;
   rqfi_pkg::kind_type    kind;
   logic                  imm;
   rqfi_pkg::status_type  imm_status;
   logic [OW-1:0]         imm_occ;

   // ring arithmetic: indices run 0..top, top = modulus - 1
   always_comb begin
      up_head  = (head_ff == top_ff) ? '0 : head_ff + 1'b1;
      up_tail  = (tail_ff == top_ff) ? '0 : tail_ff + 1'b1;
      dn_head  = (head_ff == '0) ? top_ff : head_ff - 1'b1;
      dn_tail  = (tail_ff == '0) ? top_ff : tail_ff - 1'b1;
      is_empty = (head_ff == tail_ff);
      is_full  = (up_tail == head_ff);
      if (tail_ff >= head_ff) begin
         held = HW'(tail_ff) - HW'(head_ff);
      end else begin
         held = HW'(tail_ff) + HW'(top_ff) + HW'(1) - HW'(head_ff);
      end
      occ      = held[OW-1:0];
      is_null  = (req_entry_in == '0);
      kind     = rqfi_pkg::kind_type'(req_kind);
      // new ring top from a capacity write; zero counts as one, clamp to the store
      cap_eff  = (csr_data == '0) ? CW'(1) : CW'(csr_data);
      mod_new  = cap_eff + CW'(1);
      if (mod_new > CW'(RING_SLOTS)) begin
         mod_new = CW'(RING_SLOTS);
      end
      top_new  = IDX_W'(mod_new - CW'(1));
   end

   // which request beats go through the read state
   always_comb begin
      stat.needs_read = 1'b0;
      unique case (kind)
         rqfi_pkg::KIND_POP,
         rqfi_pkg::KIND_PEEK,
         rqfi_pkg::KIND_DRAIN:      stat.needs_read = !is_empty;
         rqfi_pkg::KIND_PUSH_FRONT: stat.needs_read = is_full;
         default:                   stat.needs_read = 1'b0;
      endcase
      stat.drain_more = pend_drain_ff && (remain_ff != '0);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      head_in              = head_ff;
      tail_in              = tail_ff;
      top_in               = top_ff;
      remain_in            = remain_ff;
      pend_evict_in        = pend_evict_ff;
      pend_drain_in        = pend_drain_ff;
      pend_occ_in          = pend_occ_ff;
      we                   = 1'b0;
      waddr                = head_ff;
      re                   = 1'b0;
      raddr                = up_head;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_status_in        = rsp_status_ff;
      rsp_entry_out_in     = rsp_entry_out_ff;
      rsp_evicted_in       = rsp_evicted_ff;
      rsp_evicted_entry_in = rsp_evicted_entry_ff;
      rsp_occupancy_in     = rsp_occupancy_ff;
      rsp_last_in          = rsp_last_ff;
      imm                  = 1'b0;
      imm_status           = rqfi_pkg::ST_OK;
      imm_occ              = occ;

      if (cmd.accept) begin
         unique case (kind)
            rqfi_pkg::KIND_PUSH_TAIL: begin
               imm = 1'b1;
               if (is_null) begin
                  imm_status = rqfi_pkg::ST_NULL;
               end else if (is_full) begin
                  imm_status = rqfi_pkg::ST_FULL;
               end else begin
                  we      = 1'b1;
                  waddr   = up_tail;
                  tail_in = up_tail;
                  imm_occ = occ + 1'b1;
               end
            end
            rqfi_pkg::KIND_POP,
            rqfi_pkg::KIND_PEEK: begin
               if (is_empty) begin
                  imm        = 1'b1;
                  imm_status = rqfi_pkg::ST_EMPTY;
                  imm_occ    = '0;
               end else begin
                  re            = 1'b1;
                  raddr         = up_head;
                  pend_evict_in = 1'b0;
                  pend_drain_in = 1'b0;
                  if (kind == rqfi_pkg::KIND_POP) begin
                     head_in     = up_head;
                     pend_occ_in = occ - 1'b1;
                  end else begin
                     pend_occ_in = occ;
                  end
               end
            end
            rqfi_pkg::KIND_PUSH_FRONT: begin
               // head slot is always the open one
               we      = 1'b1;
               waddr   = head_ff;
               head_in = dn_head;
               if (is_full) begin
                  re            = 1'b1;
                  raddr         = tail_ff;
                  tail_in       = dn_tail;
                  pend_evict_in = 1'b1;
                  pend_drain_in = 1'b0;
                  pend_occ_in   = occ;
               end else begin
                  imm     = 1'b1;
                  imm_occ = occ + 1'b1;
               end
            end
            rqfi_pkg::KIND_DRAIN: begin
               if (is_empty) begin
                  imm        = 1'b1;
                  imm_status = rqfi_pkg::ST_EMPTY;
                  imm_occ    = '0;
               end else begin
                  re            = 1'b1;
                  raddr         = up_head;
                  head_in       = up_head;
                  pend_evict_in = 1'b0;
                  pend_drain_in = 1'b1;
                  pend_occ_in   = occ;
                  remain_in     = IDX_W'(held - HW'(1));
               end
            end
            rqfi_pkg::KIND_COUNT: begin
               imm = 1'b1;
            end
            default: begin
               imm = 1'b0;   // unused kinds: beat taken, nothing done
            end
         endcase
         if (imm) begin
            rsp_valid_in         = 1'b1;
            rsp_status_in        = imm_status;
            rsp_entry_out_in     = '0;
            rsp_evicted_in       = 1'b0;
            rsp_evicted_entry_in = '0;
            rsp_occupancy_in     = imm_occ;
            rsp_last_in          = 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_status_in        = rqfi_pkg::ST_OK;
         rsp_entry_out_in     = pend_evict_ff ? '0 : rd_data_ff;
         rsp_evicted_in       = pend_evict_ff;
         rsp_evicted_entry_in = pend_evict_ff ? rd_data_ff : '0;
         rsp_occupancy_in     = pend_occ_ff;
         rsp_last_in          = !pend_drain_ff || (remain_ff == '0);
      end

      if (cmd.drain_next) begin
         re        = 1'b1;
         raddr     = up_head;
         head_in   = up_head;
         remain_in = remain_ff - 1'b1;
      end

      if (csr_valid) begin
         top_in  = top_new;
         head_in = top_new;
         tail_in = top_new;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slot_store_ff[waddr] <= req_entry_in;
      end
      if (re) begin
         rd_data_ff <= slot_store_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= IDX_W'(TOP_RST);
         tail_ff      <= IDX_W'(TOP_RST);
         top_ff       <= IDX_W'(TOP_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff            <= remain_in;
      pend_evict_ff        <= pend_evict_in;
      pend_drain_ff        <= pend_drain_in;
      pend_occ_ff          <= pend_occ_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_entry_out_ff     <= rsp_entry_out_in;
      rsp_evicted_ff       <= rsp_evicted_in;
      rsp_evicted_entry_ff <= rsp_evicted_entry_in;
      rsp_occupancy_ff     <= rsp_occupancy_in;
      rsp_last_ff          <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_out     = rsp_entry_out_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_evicted_entry = rsp_evicted_entry_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
